### hdl/pi6_pkg.sv
`timescale 1ns / 1ps

package pi6_pkg;

    localparam int PHASES     = 6;
    localparam int TAP_COUNT  = 48;
    localparam int HIST_DEPTH = (TAP_COUNT + PHASES - 1) / PHASES;
    localparam int HALF_DEPTH = (HIST_DEPTH + 1) / 2;
    localparam int TABLE_LEN  = 48;
    localparam int TAB_IDX_W  = $clog2(TABLE_LEN);

    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 29;
    localparam int PROD_W     = SAMPLE_W + COEF_W;
    localparam int PART_W     = PROD_W + $clog2(HALF_DEPTH) + 1;
    localparam int ACC_W      = PART_W + 1;
    localparam int FRAC_SHIFT = 24;
    localparam int RND_W      = ACC_W - FRAC_SHIFT;
    localparam int OUT_W      = 22;
    localparam int PHASE_W    = 3;

    localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(PHASES - 1);

    localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'(1) <<< (FRAC_SHIFT - 1);
    localparam logic signed [RND_W-1:0] OUT_MAX  = RND_W'((1 << (OUT_W - 1)) - 1);
    localparam logic signed [RND_W-1:0] OUT_MIN  = -RND_W'(1 << (OUT_W - 1));

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef sample_t [HIST_DEPTH-1:0]   hist_t;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic               last;
    } pi6_ctl_t;

    // symmetric prototype, scaled by 6/4800, 40 fractional bits
    localparam logic signed [COEF_W-1:0] COEF_TAB [TABLE_LEN] = '{
        -29'sd488742,    -29'sd1235047,   -29'sd1925792,   -29'sd2360017,
        -29'sd2150524,   -29'sd863294,     29'sd1711420,    29'sd5265818,
         29'sd8814090,    29'sd10801234,   29'sd9531597,    29'sd3839522,
        -29'sd6199203,   -29'sd18784036,  -29'sd30378811,  -29'sd36295518,
        -29'sd31806817,  -29'sd13526999,   29'sd19330579,   29'sd63402829,
         29'sd115395942,  29'sd164824043,  29'sd203933533,  29'sd225534325,
         29'sd225534325,  29'sd203933533,  29'sd164824043,  29'sd115395942,
         29'sd63402829,   29'sd19330579,  -29'sd13526999,  -29'sd31806817,
        -29'sd36295518,  -29'sd30378811,  -29'sd18784036,  -29'sd6199203,
         29'sd3839522,    29'sd9531597,    29'sd10801234,   29'sd8814090,
         29'sd5265818,    29'sd1711420,   -29'sd863294,    -29'sd2150524,
        -29'sd2360017,   -29'sd1925792,   -29'sd1235047,   -29'sd488742
    };

    function automatic logic signed [COEF_W-1:0] coef_at(input logic [PHASE_W-1:0] ph,
                                                         input int tap);
        int k;
        k = PHASES * tap + int'(ph);
        if (k >= TAP_COUNT || k >= TABLE_LEN) begin
            return '0;
        end
        return COEF_TAB[k[TAB_IDX_W-1:0]];
    endfunction

endpackage

### hdl/pi6_pipe.sv
`timescale 1ns / 1ps

// products -> half sums -> total -> rounded/saturated output
module pi6_pipe (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           issue_valid,
    output logic                           issue_ready,
    input  pi6_pkg::hist_t                 hist,
    input  pi6_pkg::pi6_ctl_t              issue_ctl,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [pi6_pkg::OUT_W-1:0] m_sample_out,
    output logic [pi6_pkg::PHASE_W-1:0]    m_phase,
    output logic                           m_last
);

    logic signed [pi6_pkg::PROD_W-1:0] prod_reg  [pi6_pkg::HIST_DEPTH];
    logic signed [pi6_pkg::PROD_W-1:0] prod_next [pi6_pkg::HIST_DEPTH];
    logic signed [pi6_pkg::PART_W-1:0] part_reg  [2];
    logic signed [pi6_pkg::PART_W-1:0] part_next [2];
    logic signed [pi6_pkg::ACC_W-1:0]  acc_reg;
    logic signed [pi6_pkg::ACC_W-1:0]  acc_next;
    logic signed [pi6_pkg::ACC_W-1:0]  rnd_full;
    logic signed [pi6_pkg::RND_W-1:0]  rnd;
    logic signed [pi6_pkg::OUT_W-1:0]  out_reg;
    logic signed [pi6_pkg::OUT_W-1:0]  out_next;

    pi6_pkg::pi6_ctl_t ctl1_reg, ctl2_reg, ctl3_reg, ctl4_reg;
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    assign en4 = !v4_reg || m_ready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign issue_ready = en1;

    always_comb begin
        for (int l = 0; l < pi6_pkg::HIST_DEPTH; l++) begin
            prod_next[l] = pi6_pkg::PROD_W'(hist[l])
                         * pi6_pkg::PROD_W'(pi6_pkg::coef_at(issue_ctl.phase, l));
        end
    end

    always_comb begin
        part_next[0] = '0;
        part_next[1] = '0;
        for (int l = 0; l < pi6_pkg::HIST_DEPTH; l++) begin
            if (l < pi6_pkg::HALF_DEPTH) begin
                part_next[0] = part_next[0] + pi6_pkg::PART_W'(prod_reg[l]);
            end else begin
                part_next[1] = part_next[1] + pi6_pkg::PART_W'(prod_reg[l]);
            end
        end
    end

    assign acc_next = pi6_pkg::ACC_W'(part_reg[0]) + pi6_pkg::ACC_W'(part_reg[1]);

    // round half up, then clamp
    assign rnd_full = acc_reg + pi6_pkg::RND_BIAS;
    assign rnd      = rnd_full[pi6_pkg::ACC_W-1:pi6_pkg::FRAC_SHIFT];

    always_comb begin
        priority if (rnd > pi6_pkg::OUT_MAX) begin
            out_next = pi6_pkg::OUT_MAX[pi6_pkg::OUT_W-1:0];
        end else if (rnd < pi6_pkg::OUT_MIN) begin
            out_next = pi6_pkg::OUT_MIN[pi6_pkg::OUT_W-1:0];
        end else begin
            out_next = rnd[pi6_pkg::OUT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (en1) begin
                v1_reg <= issue_valid;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
            if (en3) begin
                v3_reg <= v2_reg;
            end
            if (en4) begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en1 && issue_valid) begin
            prod_reg <= prod_next;
            ctl1_reg <= issue_ctl;
        end
        if (en2 && v1_reg) begin
            part_reg <= part_next;
            ctl2_reg <= ctl1_reg;
        end
        if (en3 && v2_reg) begin
            acc_reg  <= acc_next;
            ctl3_reg <= ctl2_reg;
        end
        if (en4 && v3_reg) begin
            out_reg  <= out_next;
            ctl4_reg <= ctl3_reg;
        end
    end

    assign m_valid      = v4_reg;
    assign m_sample_out = out_reg;
    assign m_phase      = ctl4_reg.phase;
    assign m_last       = ctl4_reg.last;

endmodule

### hdl/polyphase_interpolator_x6.sv
`timescale 1ns / 1ps

// Interpolator by six: each input sample yields six output samples, phases 0..5, one per
// cycle unless m_ready stalls the pipeline, with m_last on phase 5. The next sample is
// taken, while busy, in the cycle its predecessor's phase 5 issues, so a new sample is not
// taken before all phases of the last one have issued. A sample passes the history register,
// products, half sums, total and rounded output registers. Output is signed with 16
// fractional bits, rounded half up and saturated to 22 bits. History resets to zeros.
module polyphase_interpolator_x6 (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic signed [pi6_pkg::SAMPLE_W-1:0] s_sample_in,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [pi6_pkg::OUT_W-1:0] m_sample_out,
    output logic [pi6_pkg::PHASE_W-1:0]      m_phase,
    output logic                             m_last
);

    pi6_pkg::hist_t            hist_reg, hist_next;
    logic                      busy_reg, busy_next;
    logic [pi6_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic                      pipe_ready;
    logic                      issue;
    logic                      issue_last;
    logic                      accept;
    pi6_pkg::pi6_ctl_t         issue_ctl;

    assign issue      = busy_reg && pipe_ready;
    assign issue_last = issue && (phase_reg == pi6_pkg::PHASE_LAST);
    assign s_ready    = !busy_reg || issue_last;
    assign accept     = s_valid && s_ready;

    assign issue_ctl.phase = phase_reg;
    assign issue_ctl.last  = (phase_reg == pi6_pkg::PHASE_LAST);

    always_comb begin
        hist_next  = hist_reg;
        busy_next  = busy_reg;
        phase_next = phase_reg;
        if (accept) begin
            hist_next = {hist_reg[pi6_pkg::HIST_DEPTH-2:0], s_sample_in};
        end
        if (accept) begin
            busy_next = 1'b1;
        end else if (issue_last) begin
            busy_next = 1'b0;
        end
        if (accept || issue_last) begin
            phase_next = '0;
        end else if (issue) begin
            phase_next = phase_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg  <= '0;
            busy_reg  <= 1'b0;
            phase_reg <= '0;
        end else begin
            hist_reg  <= hist_next;
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
        end
    end

    pi6_pipe u_pipe (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .issue_valid  (busy_reg),
        .issue_ready  (pipe_ready),
        .hist         (hist_reg),
        .issue_ctl    (issue_ctl),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out),
        .m_phase      (m_phase),
        .m_last       (m_last)
    );

    a_accept_at_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && busy_reg) |-> (phase_reg == pi6_pkg::PHASE_LAST))
        else $error("request taken before last phase issued");

    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg <= pi6_pkg::PHASE_LAST)
        else $error("phase counter out of range");

    a_idle_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(busy_reg) |-> ($past(phase_reg) == pi6_pkg::PHASE_LAST))
        else $error("went idle before last phase");

    a_out_last_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last == (m_phase == pi6_pkg::PHASE_LAST)))
        else $error("last flag does not match phase");

endmodule
